### rtl/rbfr_pkg.sv
// ----------------------------------------------------------------------------
// rbfr_pkg
// Types and constants for the remote button frame receiver.
// ----------------------------------------------------------------------------
package rbfr_pkg;

    typedef enum logic [1:0] {
        ACT_BYTE    = 2'd0,
        ACT_HELD    = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef struct packed {
        logic answer;
        logic frame_done;
        logic any_held;
    } t_result;

    localparam logic [7:0] SYNC_FIRST    = 8'hFF;
    localparam logic [7:0] SYNC_SECOND   = 8'h55;
    localparam logic [7:0] STATE_PRESSED = 8'h01;
    localparam logic [7:0] CODE_MAP_LO   = 8'h10;
    localparam logic [7:0] CODE_MAP_HI   = 8'h14;
    localparam logic [7:0] CODE_MAP_BASE = 8'd10;
    localparam logic [7:0] LEN_DROP_MIN  = 8'd254;

endpackage

### rtl/remote_button_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// remote_button_frame_receiver_unit
// Scans link bytes for 0xFF 0x55 frames, applies button code/state at frame
// end and answers held / release polls.
// ----------------------------------------------------------------------------
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+-----------------------------------
//  input   | i_in_valid   | o_in_ready   | i_action, i_rx_byte, i_button
//  output  | o_out_valid  | i_out_ready  | o_answer, o_frame_done, o_any_held
//
//  One item per cycle while o_in_ready is high; its result is registered,
//  in the skid if the output stalls. All state updates on the transfer.
//  A two-entry output (result register plus skid) keeps input transfers going
//  while one result waits; o_in_ready drops only when both entries are full.
//  Reset (synchronous, active low) clears frame state and all slot bits.
//
module remote_button_frame_receiver_unit #(
    parameter int BUTTON_SLOTS  = 32,
    parameter int CODE_POSITION = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  logic [7:0] i_rx_byte,
    input  logic [4:0] i_button,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_answer,
    output logic       o_frame_done,
    output logic       o_any_held
);

    localparam logic [7:0] CodePos  = 8'(CODE_POSITION);
    localparam logic [7:0] StatePos = 8'(CODE_POSITION + 1);
    localparam logic [7:0] SlotLim  = 8'(BUTTON_SLOTS);

    // frame state
    logic [7:0] r_prev_byte, n_prev_byte;
    logic       r_in_frame, n_in_frame;
    logic       r_await_len, n_await_len;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_frame_pos, n_frame_pos;
    logic [7:0] r_code_byte, n_code_byte;
    logic [7:0] r_state_byte, n_state_byte;

    // per-slot bits
    logic [BUTTON_SLOTS-1:0] r_held, n_held;
    logic [BUTTON_SLOTS-1:0] r_latch, n_latch;
    logic [BUTTON_SLOTS-1:0] r_snap, n_snap;

    // output register and skid
    logic                r_out_valid, r_skid_valid;
    rbfr_pkg::t_result   r_out, r_skid;
    rbfr_pkg::t_result   n_result;

    logic                    in_xfer, out_xfer;
    logic                    apply, done, answer;
    logic [7:0]              code, slot, pos_inc, keep_pos;
    logic                    keep_en;
    logic [BUTTON_SLOTS-1:0] apply_mask, poll_mask;
    rbfr_pkg::t_action       action;

    assign action   = rbfr_pkg::t_action'(i_action);
    assign o_in_ready = !r_skid_valid;
    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = r_out_valid && i_out_ready;
    assign pos_inc  = r_frame_pos + 8'd1;

    // poll slot decode; out-of-range buttons give an empty mask
    always_comb begin
        for (int i = 0; i < BUTTON_SLOTS; i++) begin
            poll_mask[i] = ({2'b00, i_button} == 7'(i));
        end
    end

    // byte parser
    always_comb begin
        n_prev_byte  = r_prev_byte;
        n_in_frame   = r_in_frame;
        n_await_len  = r_await_len;
        n_bytes_left = r_bytes_left;
        n_frame_pos  = r_frame_pos;
        apply        = 1'b0;
        keep_en      = 1'b0;
        keep_pos     = r_frame_pos;
        if (action == rbfr_pkg::ACT_BYTE) begin
            n_prev_byte = i_rx_byte;
            if (!r_in_frame) begin
                if (i_rx_byte == rbfr_pkg::SYNC_SECOND && r_prev_byte == rbfr_pkg::SYNC_FIRST) begin
                    n_in_frame  = 1'b1;
                    n_await_len = 1'b1;
                    n_frame_pos = 8'd1;
                    keep_en     = 1'b1;
                    keep_pos    = 8'd1;
                end
            end else if (r_await_len) begin
                n_await_len = 1'b0;
                if (i_rx_byte >= rbfr_pkg::LEN_DROP_MIN) begin
                    n_in_frame   = 1'b0;
                    n_frame_pos  = 8'd0;
                    n_bytes_left = 8'd0;
                end else begin
                    n_frame_pos  = 8'd2;
                    keep_en      = 1'b1;
                    keep_pos     = 8'd2;
                    n_bytes_left = i_rx_byte;
                    if (i_rx_byte == 8'd0) begin
                        apply       = 1'b1;
                        n_in_frame  = 1'b0;
                        n_frame_pos = 8'd0;
                    end
                end
            end else begin
                n_frame_pos  = pos_inc;
                keep_en      = 1'b1;
                keep_pos     = pos_inc;
                n_bytes_left = r_bytes_left - 8'd1;
                if (r_bytes_left == 8'd1) begin
                    apply       = 1'b1;
                    n_in_frame  = 1'b0;
                    n_frame_pos = 8'd0;
                end
            end
        end
        done = apply;
    end

    // keep code and state bytes at their frame positions
    always_comb begin
        n_code_byte  = r_code_byte;
        n_state_byte = r_state_byte;
        if (keep_en && keep_pos == CodePos) begin
            n_code_byte = i_rx_byte;
        end
        if (keep_en && keep_pos == StatePos) begin
            n_state_byte = i_rx_byte;
        end
    end

    // code to slot; code 0 and slots past the table leave the mask empty
    always_comb begin
        code = n_code_byte;
        if (code >= rbfr_pkg::CODE_MAP_LO && code <= rbfr_pkg::CODE_MAP_HI) begin
            code = code - rbfr_pkg::CODE_MAP_LO + rbfr_pkg::CODE_MAP_BASE;
        end
        slot = code - 8'd1;
        for (int i = 0; i < BUTTON_SLOTS; i++) begin
            apply_mask[i] = apply && (code != 8'd0) && (slot < SlotLim) && (slot == 8'(i));
        end
    end

    // slot bit updates and poll answers
    always_comb begin
        n_held  = r_held;
        n_latch = r_latch;
        n_snap  = r_snap;
        answer  = 1'b0;
        if (n_state_byte == rbfr_pkg::STATE_PRESSED) begin
            n_held  = r_held | apply_mask;
            n_latch = r_latch | apply_mask;
        end else begin
            n_held  = r_held & ~apply_mask;
        end
        case (action)
            rbfr_pkg::ACT_HELD: begin
                answer = |(r_held & poll_mask);
                n_snap = (r_snap & ~poll_mask) | (r_held & poll_mask);
            end
            rbfr_pkg::ACT_RELEASE: begin
                if (|(r_latch & poll_mask & ~r_snap)) begin
                    answer  = 1'b1;
                    n_latch = r_latch & ~poll_mask;
                end
            end
            default: begin
                answer = 1'b0;
            end
        endcase
        n_result.answer     = answer;
        n_result.frame_done = done;
        n_result.any_held   = |n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_byte  <= '0;
            r_in_frame   <= 1'b0;
            r_await_len  <= 1'b0;
            r_bytes_left <= '0;
            r_frame_pos  <= '0;
            r_code_byte  <= '0;
            r_state_byte <= '0;
            r_held       <= '0;
            r_latch      <= '0;
            r_snap       <= '0;
        end else if (in_xfer) begin
            r_prev_byte  <= n_prev_byte;
            r_in_frame   <= n_in_frame;
            r_await_len  <= n_await_len;
            r_bytes_left <= n_bytes_left;
            r_frame_pos  <= n_frame_pos;
            r_code_byte  <= n_code_byte;
            r_state_byte <= n_state_byte;
            r_held       <= n_held;
            r_latch      <= n_latch;
            r_snap       <= n_snap;
        end
    end

    // result register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_xfer) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (in_xfer) begin
            if (!r_out_valid || out_xfer) begin
                r_out       <= n_result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= n_result;
                r_skid_valid <= 1'b1;
            end
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_answer     = r_out.answer;
    assign o_frame_done = r_out.frame_done;
    assign o_any_held   = r_out.any_held;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a result in the output register");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_out_valid && !i_out_ready) |=> r_skid_valid)
        else $error("result lost on a stalled output");

    a_len_only_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await_len |-> (r_in_frame && r_frame_pos == 8'd1))
        else $error("length wait outside an open frame");

    a_body_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_frame && !r_await_len) |-> (r_bytes_left != 8'd0))
        else $error("open frame body with no bytes left");

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for remote_button_frame_receiver_unit. Drives link bytes
// and held/release polls over the input channel, predicts each result with a
// bit-level model of the frame scanner and slot tables, and compares every
// output transfer in order. Runs directed frames first, then random traffic
// under several sender/receiver idle mixes, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

    localparam int SLOTS       = 32;
    localparam int CODE_POS    = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int STUCK_LIMIT = 2000;
    localparam int MAX_GAP     = 60;

    // Predicts one result per input transfer and checks results in order.
    class button_frame_scoreboard;
        rbfr_pkg::t_result expected_q[$];
        int unsigned errors;
        logic [7:0]  last_byte;
        logic [7:0]  code_val;
        logic [7:0]  state_val;
        logic [7:0]  remaining;
        logic [7:0]  position;
        bit          frame_open;
        bit          want_length;
        logic [SLOTS-1:0] held;
        logic [SLOTS-1:0] latch;
        logic [SLOTS-1:0] snapshot;

        function new();
            errors      = 0;
            last_byte   = '0;
            code_val    = '0;
            state_val   = '0;
            remaining   = '0;
            position    = '0;
            frame_open  = 1'b0;
            want_length = 1'b0;
            held        = '0;
            latch       = '0;
            snapshot    = '0;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function void keep_field(logic [7:0] b);
            if (position == CODE_POS)
                code_val = b;
            if (position == CODE_POS + 1)
                state_val = b;
        endfunction

        function void apply_frame();
            int unsigned code;
            int unsigned slot;
            code = code_val;
            if (code >= rbfr_pkg::CODE_MAP_LO && code <= rbfr_pkg::CODE_MAP_HI)
                code = code - rbfr_pkg::CODE_MAP_LO + rbfr_pkg::CODE_MAP_BASE;
            if (code == 0)
                return;
            slot = code - 1;
            if (slot >= SLOTS)
                return;
            if (state_val == rbfr_pkg::STATE_PRESSED) begin
                held[slot]  = 1'b1;
                latch[slot] = 1'b1;
            end else begin
                held[slot] = 1'b0;
            end
        endfunction

        function bit take_byte(logic [7:0] b);
            bit done;
            done = 1'b0;
            if (!frame_open) begin
                if (b == rbfr_pkg::SYNC_SECOND && last_byte == rbfr_pkg::SYNC_FIRST) begin
                    frame_open  = 1'b1;
                    want_length = 1'b1;
                    position    = 8'd1;
                    keep_field(b);
                end
            end else if (want_length) begin
                want_length = 1'b0;
                if (b >= rbfr_pkg::LEN_DROP_MIN) begin
                    frame_open = 1'b0;
                    position   = '0;
                    remaining  = '0;
                end else begin
                    position  = 8'd2;
                    keep_field(b);
                    remaining = b;
                    if (remaining == 0) begin
                        apply_frame();
                        frame_open = 1'b0;
                        position   = '0;
                        done       = 1'b1;
                    end
                end
            end else begin
                position = position + 8'd1;
                keep_field(b);
                remaining = remaining - 8'd1;
                if (remaining == 0) begin
                    apply_frame();
                    frame_open = 1'b0;
                    position   = '0;
                    done       = 1'b1;
                end
            end
            last_byte = b;
            return done;
        endfunction

        function void note_input(rbfr_pkg::t_action act, logic [7:0] b, logic [4:0] btn);
            rbfr_pkg::t_result r;
            r = '0;
            case (act)
                rbfr_pkg::ACT_BYTE: r.frame_done = take_byte(b);
                rbfr_pkg::ACT_HELD: begin
                    r.answer      = held[btn];
                    snapshot[btn] = held[btn];
                end
                rbfr_pkg::ACT_RELEASE: begin
                    // release reported once, and only if the last held poll saw it up
                    if (latch[btn] && !snapshot[btn]) begin
                        latch[btn] = 1'b0;
                        r.answer   = 1'b1;
                    end
                end
                default: ;
            endcase
            r.any_held = |held;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic answer, logic frame_done, logic any_held);
            rbfr_pkg::t_result e;
            if (expected_q.size() == 0) begin
                $error("result transfer with no prediction outstanding");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (answer !== e.answer) begin
                $error("answer: expected %0b, actual %0b", e.answer, answer);
                errors++;
            end
            if (frame_done !== e.frame_done) begin
                $error("frame_done: expected %0b, actual %0b", e.frame_done, frame_done);
                errors++;
            end
            if (any_held !== e.any_held) begin
                $error("any_held: expected %0b, actual %0b", e.any_held, any_held);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [1:0] i_action    = rbfr_pkg::ACT_NONE;
    logic [7:0] i_rx_byte   = '0;
    logic [4:0] i_button    = '0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_answer;
    logic       o_frame_done;
    logic       o_any_held;

    button_frame_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    int items_sent     = 0;
    int stuck_cycles   = 0;

    remote_button_frame_receiver_unit #(
        .BUTTON_SLOTS (SLOTS),
        .CODE_POSITION(CODE_POS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_rx_byte   (i_rx_byte),
        .i_button    (i_button),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_answer    (o_answer),
        .o_frame_done(o_frame_done),
        .o_any_held  (o_any_held)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(rbfr_pkg::t_action act, logic [7:0] b, logic [4:0] btn);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_rx_byte  <= b;
        i_button   <= btn;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_input(act, b, btn);
        if (act != rbfr_pkg::ACT_NONE)
            items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(rbfr_pkg::ACT_BYTE, b, 5'($urandom_range(31)));
    endtask

    // Sync pair, length, then body bytes after the length (body < len leaves it open).
    task automatic send_frame(logic [7:0] len, logic [7:0] code, logic [7:0] st, int body);
        int p;
        logic [7:0] fill;
        send_byte(rbfr_pkg::SYNC_FIRST);
        send_byte(rbfr_pkg::SYNC_SECOND);
        send_byte(len);
        for (p = 3; p < body + 3; p++) begin
            case ($urandom_range(9))
                0:       fill = rbfr_pkg::SYNC_FIRST;
                1:       fill = rbfr_pkg::SYNC_SECOND;
                default: fill = 8'($urandom_range(255));
            endcase
            if (p == CODE_POS)
                fill = code;
            else if (p == CODE_POS + 1)
                fill = st;
            send_byte(fill);
        end
    endtask

    function automatic logic [7:0] pick_code();
        case ($urandom_range(9))
            0, 1, 2, 3: return 8'($urandom_range(rbfr_pkg::CODE_MAP_HI, rbfr_pkg::CODE_MAP_LO));
            4, 5:       return 8'($urandom_range(15, 1));
            6:          return 8'($urandom_range(8'h20, 8'h15));
            7:          return 8'h00;
            8:          return 8'($urandom_range(255, 8'h21));
            default:    return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] pick_state();
        if ($urandom_range(1))
            return rbfr_pkg::STATE_PRESSED;
        return 8'($urandom_range(255));
    endfunction

    task automatic run_random(int count);
        int stop_at;
        int sel;
        int r;
        logic [7:0] len;
        logic [4:0] btn;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            sel = $urandom_range(99);
            if (sel < 50) begin
                r = $urandom_range(99);
                if (r < 65)
                    len = 8'($urandom_range(14, 11));
                else if (r < 85)
                    len = 8'($urandom_range(10, 0));
                else if (r < 95)
                    len = 8'($urandom_range(40, 15));
                else if (r < 97)
                    len = 8'($urandom_range(253, 41));
                else
                    len = 8'($urandom_range(255, rbfr_pkg::LEN_DROP_MIN));
                send_frame(len, pick_code(), pick_state(),
                           (len >= rbfr_pkg::LEN_DROP_MIN) ? 0 : int'(len));
            end else if (sel < 80) begin
                // mapped codes land on slots 9..13, so poll those often
                if ($urandom_range(99) < 40)
                    btn = 5'($urandom_range(13, 9));
                else
                    btn = 5'($urandom_range(31));
                send_item(rbfr_pkg::t_action'($urandom_range(rbfr_pkg::ACT_RELEASE,
                                                              rbfr_pkg::ACT_HELD)),
                          8'($urandom_range(255)), btn);
            end else if (sel < 90) begin
                if ($urandom_range(1))
                    send_item(rbfr_pkg::ACT_NONE, 8'($urandom_range(255)),
                              5'($urandom_range(31)));
                else
                    send_byte(8'($urandom_range(255)));
            end else begin
                // broken frame: stops short, later traffic runs on as its body
                len = 8'($urandom_range(40, 11));
                send_frame(len, pick_code(), pick_state(), $urandom_range(int'(len) - 1));
            end
        end
    endtask

    // Receiver: random stalls, or one long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_answer, o_frame_done, o_any_held);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        int ph;
        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: polls from reset, unused action
        send_item(rbfr_pkg::ACT_HELD, 8'h00, 5'd0);
        send_item(rbfr_pkg::ACT_RELEASE, 8'hFF, 5'd31);
        send_item(rbfr_pkg::ACT_NONE, 8'hA5, 5'd21);
        // frame closing on FF 55 must not reopen; stale zero code, no slot change
        send_byte(rbfr_pkg::SYNC_FIRST);
        send_byte(rbfr_pkg::SYNC_SECOND);
        send_byte(8'd2);
        send_byte(rbfr_pkg::SYNC_FIRST);
        send_byte(rbfr_pkg::SYNC_SECOND);
        send_byte(8'd0);
        // zero length ends on the length byte; 254 is dropped
        send_frame(8'd0, 8'h00, 8'h00, 0);
        send_frame(rbfr_pkg::LEN_DROP_MIN, 8'h00, 8'h00, 0);
        // press of mapped code 0x14 -> slot 13, then release/held polls
        send_frame(8'd11, rbfr_pkg::CODE_MAP_HI, rbfr_pkg::STATE_PRESSED, 11);
        send_item(rbfr_pkg::ACT_RELEASE, 8'h00, 5'd13);
        send_item(rbfr_pkg::ACT_HELD, 8'hFF, 5'd13);
        send_item(rbfr_pkg::ACT_RELEASE, 8'h00, 5'd13);

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_request   = 1'b1;
                end
                1: begin
                    send_idle_pct  = 77;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 77;
                end
                default: begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 7;
                end
            endcase
            run_random(250);
        end
        i_in_valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### files.f
rtl/rbfr_pkg.sv
rtl/remote_button_frame_receiver_unit.sv
dv/tb.sv
